// ===== rtl/core/mltq_pkg.sv =====
// Package for the multi-level task queue: sizes, codes, the pointer helper
// and the struct that carries the scheduling decision. No dependencies.
`timescale 1ns / 1ps

package mltq_pkg;

   localparam int LEVELS  = 3;
   localparam int DEPTH   = 32;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int SLOTS   = LEVELS * DEPTH;
   localparam int ADDR_W  = $clog2(SLOTS);
   localparam int LIDX_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int LEVEL_W = 2;
   localparam int WORD_W  = 32;
   localparam int SLOT_W  = 2 * WORD_W;

   typedef enum logic [1:0] {
      ST_ENQUEUED   = 2'd0,
      ST_DROPPED    = 2'd1,
      ST_DISPATCHED = 2'd2,
      ST_NONE       = 2'd3
   } status_type;

   typedef enum logic {
      ACT_ENQUEUE  = 1'b0,
      ACT_DISPATCH = 1'b1
   } action_type;

   typedef struct packed {
      logic               mem_wr;
      logic               mem_rd;
      status_type         status;
      logic [LEVEL_W-1:0] level;
      logic [ADDR_W-1:0]  addr;
   } sched_type;

   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

endpackage

// ===== rtl/core/mltq_if.sv =====
// Handshake channels of the multi-level task queue: request and response words.
// Depends on mltq_pkg for field widths and codes.
`timescale 1ns / 1ps

interface mltq_req_if;
   import mltq_pkg::*;

   logic                valid;
   logic                ready;
   action_type          action;
   logic [LEVEL_W-1:0]  level;
   logic [WORD_W-1:0]   task_handle;
   logic [WORD_W-1:0]   task_arg;

   modport source (output valid, output action, output level, output task_handle,
                   output task_arg, input ready);
   modport sink   (input valid, input action, input level, input task_handle,
                   input task_arg, output ready);
endinterface

interface mltq_rsp_if;
   import mltq_pkg::*;

   logic                valid;
   logic                ready;
   status_type          status;
   logic [LEVEL_W-1:0]  out_level;
   logic [WORD_W-1:0]   out_handle;
   logic [WORD_W-1:0]   out_arg;

   modport source (output valid, output status, output out_level, output out_handle,
                   output out_arg, input ready);
   modport sink   (input valid, input status, input out_level, input out_handle,
                   input out_arg, output ready);
endinterface

// ===== rtl/core/mltq_sched.sv =====
// Read and write pointers of every level plus the full, empty and priority
// decision for one word. Depends on mltq_pkg.
`timescale 1ns / 1ps

module mltq_sched (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  mltq_pkg::action_type          action,
   input  logic [mltq_pkg::LEVEL_W-1:0]  level,
   output mltq_pkg::sched_type           sched
);
   import mltq_pkg::*;

   logic [PTR_W-1:0]  rd_ptr_ff [LEVELS];
   logic [PTR_W-1:0]  wr_ptr_ff [LEVELS];
   logic [PTR_W-1:0]  rd_ptr_in [LEVELS];
   logic [PTR_W-1:0]  wr_ptr_in [LEVELS];

   logic              found;
   logic              full;
   logic              lvl_ok;
   logic [LIDX_W-1:0] sel_lvl;
   logic [PTR_W-1:0]  sel_ptr;

   // Scan the levels: an enqueue looks at its own level, a dispatch takes the
   // lowest non-empty level at or above the requested one.
   always_comb begin
      found   = 1'b0;
      full    = 1'b0;
      lvl_ok  = 1'b0;
      sel_lvl = '0;
      sel_ptr = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (action == ACT_ENQUEUE) begin
            if (32'(level) == l) begin
               lvl_ok  = 1'b1;
               sel_lvl = LIDX_W'(l);
               sel_ptr = wr_ptr_ff[l];
               full    = (ptr_advance(wr_ptr_ff[l]) == rd_ptr_ff[l]);
            end
         end else begin
            if (!found && (l >= 32'(level)) && (rd_ptr_ff[l] != wr_ptr_ff[l])) begin
               found   = 1'b1;
               sel_lvl = LIDX_W'(l);
               sel_ptr = rd_ptr_ff[l];
            end
         end
      end

      sched.addr   = ADDR_W'(sel_lvl) * ADDR_W'(DEPTH) + ADDR_W'(sel_ptr);
      sched.level  = LEVEL_W'(sel_lvl);
      sched.mem_wr = (action == ACT_ENQUEUE) && lvl_ok && !full;
      sched.mem_rd = (action == ACT_DISPATCH) && found;
      if (action == ACT_ENQUEUE) begin
         sched.status = sched.mem_wr ? ST_ENQUEUED : ST_DROPPED;
      end else begin
         sched.status = found ? ST_DISPATCHED : ST_NONE;
      end
   end

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         rd_ptr_in[l] = rd_ptr_ff[l];
         wr_ptr_in[l] = wr_ptr_ff[l];
         if (fire && (32'(sel_lvl) == l)) begin
            if (sched.mem_wr) begin
               wr_ptr_in[l] = ptr_advance(wr_ptr_ff[l]);
            end
            if (sched.mem_rd) begin
               rd_ptr_in[l] = ptr_advance(rd_ptr_ff[l]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LEVELS; l++) begin
         if (reset) begin
            rd_ptr_ff[l] <= '0;
            wr_ptr_ff[l] <= '0;
         end else begin
            rd_ptr_ff[l] <= rd_ptr_in[l];
            wr_ptr_ff[l] <= wr_ptr_in[l];
         end
      end
   end

endmodule

// ===== rtl/core/multi_level_task_queue.sv =====
// Multi-level task queue: one circular FIFO per priority level in a shared slot RAM.
// A request word passes stage one and the output register before its response word.
// Throughput: one request word per cycle while responses are taken; the pointers
// resolve in the accept cycle and the single-port slot RAM is touched once per word.
// Reset (synchronous, active high) empties every level; the slot RAM is not cleared.
// Depends on mltq_pkg, mltq_if (channels) and mltq_sched (pointer logic).
`timescale 1ns / 1ps

module multi_level_task_queue (
   input  logic         clock,
   input  logic         reset,
   mltq_req_if.sink     req_chan,
   mltq_rsp_if.source   rsp_chan
);
   import mltq_pkg::*;

   // Slot RAM: entry (level * DEPTH + pointer) holds {argument, handle}.
   // Slots are only ever read between the read and write pointers of a
   // level, so every slot read was written by an earlier word.
   logic [SLOT_W-1:0]  slot_mem [SLOTS];
   logic [SLOT_W-1:0]  mem_rdata_ff;

   sched_type          sched;
   logic               fire;
   logic               out_free;
   logic               s1_move;

   // Stage one: the word whose RAM read is in flight.
   logic               s1_valid_ff;
   logic               s1_valid_in;
   status_type         s1_status_ff;
   logic [LEVEL_W-1:0] s1_level_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   status_type         rsp_status_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic [WORD_W-1:0]  rsp_handle_ff;
   logic [WORD_W-1:0]  rsp_arg_ff;

   mltq_sched u_sched (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .action (req_chan.action),
      .level  (req_chan.level),
      .sched  (sched)
   );

   // The output register empties or is taken this cycle, so stage one can
   // advance; a new word may enter whenever stage one advances or is empty.
   // The pointers update at the accept edge, so back-to-back words on the
   // same level see each other's effect without any forwarding.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_move        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign fire           = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // RAM port: a read only happens at an accept, so the read data register
   // holds its value for as long as stage one is stalled.
   always_ff @(posedge clock) begin
      if (fire && sched.mem_wr) begin
         slot_mem[sched.addr] <= {req_chan.task_arg, req_chan.task_handle};
      end
      if (fire && sched.mem_rd) begin
         mem_rdata_ff <= slot_mem[sched.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_status_ff <= sched.status;
         s1_level_ff  <= sched.level;
      end
   end

   // Level, handle and argument read as zero unless a task was dispatched.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_status_ff <= s1_status_ff;
         if (s1_status_ff == ST_DISPATCHED) begin
            rsp_level_ff  <= s1_level_ff;
            rsp_handle_ff <= mem_rdata_ff[WORD_W-1:0];
            rsp_arg_ff    <= mem_rdata_ff[SLOT_W-1:WORD_W];
         end else begin
            rsp_level_ff  <= '0;
            rsp_handle_ff <= '0;
            rsp_arg_ff    <= '0;
         end
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.out_level  = rsp_level_ff;
   assign rsp_chan.out_handle = rsp_handle_ff;
   assign rsp_chan.out_arg    = rsp_arg_ff;

endmodule
